// ----- rtl/circle_through_three_points_defines.svh -----
// Assertion macros for the circle-through-three-points block.
// Included by the top level; depends on i_clk and i_rst_n in scope.
`ifndef CIRCLE_THROUGH_THREE_POINTS_DEFINES_SVH
`define CIRCLE_THROUGH_THREE_POINTS_DEFINES_SVH

// Clocked assertion, masked while reset is low.
`define CTP_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define CTP_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ----- rtl/ctp_pkg.sv -----
// Shared types and constants of the circle-through-three-points block.
// No dependencies.
`timescale 1ns / 1ps

package ctp_pkg;

    // Width of the center and radius results.
    localparam int OUT_BITS = 24;

    // One result transaction.
    typedef struct packed {
        logic                       fit_valid;
        logic signed [OUT_BITS-1:0] center_x;
        logic signed [OUT_BITS-1:0] center_y;
        logic        [OUT_BITS-1:0] radius_out;
        logic                       radius_ok;
        logic                       saturated;
    } t_result;

endpackage

// ----- rtl/circle_through_three_points.sv -----
// Circle through three pixel points: fully pipelined fit kernel.
// Depends on ctp_pkg, ctp_div_cell, ctp_sqrt_cell and the defines header.
//
// Usage:
//   Input channel i_in_valid / o_in_ready carries three points (ax, ay),
//   (bx, by_coord), (qx, qy). Output channel o_out_valid / i_out_ready
//   carries fit_valid, center_x, center_y (signed, FRAC_BITS fraction),
//   radius_out (unsigned), radius_ok and saturated. One result per input.
//   Config channel i_cfg_valid / o_cfg_ready writes the radius limit;
//   always ready.
// Throughput: one transaction per cycle while the skid entry is empty. Each of the two center dividers
//   is a chain of 3*COORD_BITS+FRAC_BITS+3 cells, one quotient bit each,
//   and the radius root is a chain of 25 cells, one root bit each.
// Path: input capture and front stages, the two divider chains side by side,
//   the back stages, the root chain and the result register.
// Stall: the output register is backed by a one-entry skid buffer, so a
//   new transaction is still taken in the cycle the result first waits;
//   while the skid entry is full the whole pipeline holds.
// Reset: synchronous, active low; clears all valid bits and sets
//   the radius limit to 2867.
`timescale 1ns / 1ps
`include "circle_through_three_points_defines.svh"

module circle_through_three_points #(
    parameter int COORD_BITS = 12,
    parameter int FRAC_BITS  = 4
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic [COORD_BITS-1:0]              i_ax,
    input  logic [COORD_BITS-1:0]              i_ay,
    input  logic [COORD_BITS-1:0]              i_bx,
    input  logic [COORD_BITS-1:0]              i_by_coord,
    input  logic [COORD_BITS-1:0]              i_qx,
    input  logic [COORD_BITS-1:0]              i_qy,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic                               o_fit_valid,
    output logic signed [ctp_pkg::OUT_BITS-1:0] o_center_x,
    output logic signed [ctp_pkg::OUT_BITS-1:0] o_center_y,
    output logic [ctp_pkg::OUT_BITS-1:0]       o_radius_out,
    output logic                               o_radius_ok,
    output logic                               o_saturated,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [ctp_pkg::OUT_BITS-1:0]       i_cfg_data
);

    import ctp_pkg::*;

    localparam int N     = COORD_BITS;
    localparam int DW    = N + 1;              // coordinate differences
    localparam int SW    = N + 2;              // coordinate sums, signed
    localparam int EW    = 2*N + 3;            // e, f, g
    localparam int PW    = 2*N + 2;            // determinant products
    localparam int NW    = 3*N + 4;            // center numerators
    localparam int GM    = 2*N + 2;            // |g| magnitude
    localparam int QB    = 3*N + 3 + FRAC_BITS; // quotient bits
    localparam int XS    = 2 + 2*N;            // x-divider sideband
    localparam int RB    = OUT_BITS + 1;       // root bits
    localparam int QS    = 3 + 2*OUT_BITS;     // root sideband
    localparam int PRE   = 7;
    localparam int POST  = 5;
    localparam logic [OUT_BITS-1:0] OUT_MASK = {OUT_BITS{1'b1}};
    localparam logic signed [OUT_BITS-1:0] S_MAX = {1'b0, {(OUT_BITS-1){1'b1}}};
    localparam logic signed [OUT_BITS-1:0] S_MIN = {1'b1, {(OUT_BITS-1){1'b0}}};
    localparam logic [OUT_BITS-1:0] LIMIT_RESET = OUT_BITS'(2867);

    // Flow control
    logic r_skid_v, r_out_v;
    logic en, accept;
    assign en         = !r_skid_v;
    assign accept     = i_in_valid && en;
    assign o_in_ready = en;

    // Configuration register
    logic [OUT_BITS-1:0] r_radius_limit;
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius_limit <= LIMIT_RESET;
        end else if (i_cfg_valid) begin
            r_radius_limit <= i_cfg_data;
        end
    end

    // Valid bits of the front and back arithmetic stages
    logic [PRE-1:0]  r_pv;
    logic [POST-1:0] r_qv;
    logic            xdiv_v, ydiv_v, sq_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= '0;
            r_qv <= '0;
        end else if (en) begin
            r_pv <= {r_pv[PRE-2:0], accept};
            r_qv <= {r_qv[POST-2:0], xdiv_v};
        end
    end

    // Stage 0: capture points
    logic [N-1:0] r0_x1, r0_y1, r0_x2, r0_y2, r0_x3, r0_y3;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r0_x1 <= i_ax;
            r0_y1 <= i_ay;
            r0_x2 <= i_bx;
            r0_y2 <= i_by_coord;
            r0_x3 <= i_qx;
            r0_y3 <= i_qy;
        end
    end

    // Stage 1: differences and sums
    logic signed [DW-1:0] r1_a, r1_b, r1_c, r1_d, r1_dy32, r1_dx32;
    logic signed [SW-1:0] r1_sx2, r1_sy2, r1_sx3, r1_sy3;
    logic [N-1:0]         r1_x1, r1_y1;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_a    <= $signed({1'b0, r0_x2}) - $signed({1'b0, r0_x1});
            r1_b    <= $signed({1'b0, r0_y2}) - $signed({1'b0, r0_y1});
            r1_c    <= $signed({1'b0, r0_x3}) - $signed({1'b0, r0_x1});
            r1_d    <= $signed({1'b0, r0_y3}) - $signed({1'b0, r0_y1});
            r1_dy32 <= $signed({1'b0, r0_y3}) - $signed({1'b0, r0_y2});
            r1_dx32 <= $signed({1'b0, r0_x3}) - $signed({1'b0, r0_x2});
            r1_sx2  <= $signed({2'b00, r0_x1} + {2'b00, r0_x2});
            r1_sy2  <= $signed({2'b00, r0_y1} + {2'b00, r0_y2});
            r1_sx3  <= $signed({2'b00, r0_x1} + {2'b00, r0_x3});
            r1_sy3  <= $signed({2'b00, r0_y1} + {2'b00, r0_y3});
            r1_x1   <= r0_x1;
            r1_y1   <= r0_y1;
        end
    end

    // Stage 2: first products
    logic signed [EW-1:0] r2_as, r2_bs, r2_cs, r2_ds;
    logic signed [PW-1:0] r2_p1, r2_p2;
    logic signed [DW-1:0] r2_a, r2_b, r2_c, r2_d;
    logic [N-1:0]         r2_x1, r2_y1;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_as <= EW'(r1_a * r1_sx2);
            r2_bs <= EW'(r1_b * r1_sy2);
            r2_cs <= EW'(r1_c * r1_sx3);
            r2_ds <= EW'(r1_d * r1_sy3);
            r2_p1 <= PW'(r1_a * r1_dy32);
            r2_p2 <= PW'(r1_b * r1_dx32);
            r2_a  <= r1_a;
            r2_b  <= r1_b;
            r2_c  <= r1_c;
            r2_d  <= r1_d;
            r2_x1 <= r1_x1;
            r2_y1 <= r1_y1;
        end
    end

    // Stage 3: e, f and the doubled determinant g
    logic signed [EW-1:0] r3_e, r3_f, r3_g;
    logic signed [PW-1:0] det;
    logic signed [DW-1:0] r3_a, r3_b, r3_c, r3_d;
    logic [N-1:0]         r3_x1, r3_y1;
    assign det = r2_p1 - r2_p2;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_e  <= r2_as + r2_bs;
            r3_f  <= r2_cs + r2_ds;
            r3_g  <= {det, 1'b0};
            r3_a  <= r2_a;
            r3_b  <= r2_b;
            r3_c  <= r2_c;
            r3_d  <= r2_d;
            r3_x1 <= r2_x1;
            r3_y1 <= r2_y1;
        end
    end

    // Stage 4: numerator products
    logic signed [NW-1:0] r4_de, r4_bf, r4_af, r4_ce;
    logic signed [EW-1:0] r4_g;
    logic [N-1:0]         r4_x1, r4_y1;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r4_de <= NW'(r3_d * r3_e);
            r4_bf <= NW'(r3_b * r3_f);
            r4_af <= NW'(r3_a * r3_f);
            r4_ce <= NW'(r3_c * r3_e);
            r4_g  <= r3_g;
            r4_x1 <= r3_x1;
            r4_y1 <= r3_y1;
        end
    end

    // Stage 5: numerators
    logic signed [NW-1:0] r5_nx, r5_ny;
    logic signed [EW-1:0] r5_g;
    logic [N-1:0]         r5_x1, r5_y1;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r5_nx <= r4_de - r4_bf;
            r5_ny <= r4_af - r4_ce;
            r5_g  <= r4_g;
            r5_x1 <= r4_x1;
            r5_y1 <= r4_y1;
        end
    end

    // Stage 6: signs and magnitudes for the dividers
    logic [NW-1:0]  abs_nx, abs_ny;
    logic [EW-1:0]  abs_g;
    logic [QB-1:0]  r6_wx, r6_wy;
    logic [GM-1:0]  r6_den;
    logic           r6_negx, r6_negy, r6_gz;
    logic [N-1:0]   r6_x1, r6_y1;
    always_comb begin
        abs_nx = r5_nx[NW-1] ? NW'(-r5_nx) : NW'(r5_nx);
        abs_ny = r5_ny[NW-1] ? NW'(-r5_ny) : NW'(r5_ny);
        abs_g  = r5_g[EW-1]  ? EW'(-r5_g)  : EW'(r5_g);
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r6_wx   <= QB'(abs_nx[NW-2:0]) << FRAC_BITS;
            r6_wy   <= QB'(abs_ny[NW-2:0]) << FRAC_BITS;
            r6_den  <= abs_g[GM-1:0];
            r6_negx <= r5_nx[NW-1] ^ r5_g[EW-1];
            r6_negy <= r5_ny[NW-1] ^ r5_g[EW-1];
            r6_gz   <= (r5_g == '0);
            r6_x1   <= r5_x1;
            r6_y1   <= r5_y1;
        end
    end

    // Divider chains, one quotient bit per cell
    logic [QB:0]         xv, yv;
    logic [GM-1:0]       xrem [QB+1];
    logic [GM-1:0]       yrem [QB+1];
    logic [QB-1:0]       xword [QB+1];
    logic [QB-1:0]       yword [QB+1];
    logic [GM-1:0]       xden [QB+1];
    logic [GM-1:0]       yden [QB+1];
    logic [XS-1:0]       xside [QB+1];
    logic [0:0]          yside [QB+1];

    assign xv[0]    = r_pv[PRE-1];
    assign yv[0]    = r_pv[PRE-1];
    assign xrem[0]  = '0;
    assign yrem[0]  = '0;
    assign xword[0] = r6_wx;
    assign yword[0] = r6_wy;
    assign xden[0]  = r6_den;
    assign yden[0]  = r6_den;
    assign xside[0] = {r6_gz, r6_negx, r6_x1, r6_y1};
    assign yside[0] = r6_negy;

    for (genvar k = 0; k < QB; k++) begin : g_div
        ctp_div_cell #(.DEN_BITS(GM), .QUOT_BITS(QB), .SIDE_BITS(XS)) u_xcell (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en),
            .i_valid(xv[k]), .i_rem(xrem[k]), .i_word(xword[k]),
            .i_den(xden[k]), .i_side(xside[k]),
            .o_valid(xv[k+1]), .o_rem(xrem[k+1]), .o_word(xword[k+1]),
            .o_den(xden[k+1]), .o_side(xside[k+1])
        );
        ctp_div_cell #(.DEN_BITS(GM), .QUOT_BITS(QB), .SIDE_BITS(1)) u_ycell (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en),
            .i_valid(yv[k]), .i_rem(yrem[k]), .i_word(yword[k]),
            .i_den(yden[k]), .i_side(yside[k]),
            .o_valid(yv[k+1]), .o_rem(yrem[k+1]), .o_word(yword[k+1]),
            .o_den(yden[k+1]), .o_side(yside[k+1])
        );
    end

    assign xdiv_v = xv[QB];
    assign ydiv_v = yv[QB];

    // Post 1: signed centers and clipping to the output range
    logic                   q_gz, q_negx, q_negy;
    logic [N-1:0]           q_x1, q_y1;
    logic signed [QB:0]     cx, cy;
    logic                   clipx, clipy;
    logic signed [QB:0]     p1_cx, p1_cy;
    logic signed [OUT_BITS-1:0] p1_ox, p1_oy;
    logic                   p1_satc, p1_gz;
    logic [N-1:0]           p1_x1, p1_y1;

    assign {q_gz, q_negx, q_x1, q_y1} = xside[QB];
    assign q_negy = yside[QB][0];

    always_comb begin
        cx    = q_negx ? -$signed({1'b0, xword[QB]}) : $signed({1'b0, xword[QB]});
        cy    = q_negy ? -$signed({1'b0, yword[QB]}) : $signed({1'b0, yword[QB]});
        clipx = (cx[QB:OUT_BITS-1] != '0) && (cx[QB:OUT_BITS-1] != '1);
        clipy = (cy[QB:OUT_BITS-1] != '0) && (cy[QB:OUT_BITS-1] != '1);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            p1_cx   <= cx;
            p1_cy   <= cy;
            p1_ox   <= clipx ? (cx[QB] ? S_MIN : S_MAX) : cx[OUT_BITS-1:0];
            p1_oy   <= clipy ? (cy[QB] ? S_MIN : S_MAX) : cy[OUT_BITS-1:0];
            p1_satc <= clipx || clipy;
            p1_gz   <= q_gz;
            p1_x1   <= q_x1;
            p1_y1   <= q_y1;
        end
    end

    // Post 2: offsets from the first point
    logic signed [QB+1:0]       p2_dx, p2_dy;
    logic signed [OUT_BITS-1:0] p2_ox, p2_oy;
    logic                       p2_satc, p2_gz;
    always_ff @(posedge i_clk) begin
        if (en) begin
            p2_dx   <= (QB+2)'(p1_cx) - ($signed((QB+2)'(p1_x1)) <<< FRAC_BITS);
            p2_dy   <= (QB+2)'(p1_cy) - ($signed((QB+2)'(p1_y1)) <<< FRAC_BITS);
            p2_ox   <= p1_ox;
            p2_oy   <= p1_oy;
            p2_satc <= p1_satc;
            p2_gz   <= p1_gz;
        end
    end

    // Post 3: magnitudes and the too-far check
    logic [QB+1:0]              adx, ady;
    logic [OUT_BITS-1:0]        p3_adx, p3_ady;
    logic                       p3_rclip;
    logic signed [OUT_BITS-1:0] p3_ox, p3_oy;
    logic                       p3_satc, p3_gz;
    always_comb begin
        adx = p2_dx[QB+1] ? (QB+2)'(-p2_dx) : (QB+2)'(p2_dx);
        ady = p2_dy[QB+1] ? (QB+2)'(-p2_dy) : (QB+2)'(p2_dy);
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            p3_adx   <= adx[OUT_BITS-1:0];
            p3_ady   <= ady[OUT_BITS-1:0];
            p3_rclip <= (adx[QB+1:OUT_BITS] != '0) || (ady[QB+1:OUT_BITS] != '0);
            p3_ox    <= p2_ox;
            p3_oy    <= p2_oy;
            p3_satc  <= p2_satc;
            p3_gz    <= p2_gz;
        end
    end

    // Post 4: squares
    logic [2*OUT_BITS-1:0]      p4_sx, p4_sy;
    logic                       p4_rclip;
    logic signed [OUT_BITS-1:0] p4_ox, p4_oy;
    logic                       p4_satc, p4_gz;
    always_ff @(posedge i_clk) begin
        if (en) begin
            p4_sx    <= p3_adx * p3_adx;
            p4_sy    <= p3_ady * p3_ady;
            p4_rclip <= p3_rclip;
            p4_ox    <= p3_ox;
            p4_oy    <= p3_oy;
            p4_satc  <= p3_satc;
            p4_gz    <= p3_gz;
        end
    end

    // Post 5: radicand
    logic [2*RB-1:0] p5_rad;
    logic [QS-1:0]   p5_side;
    always_ff @(posedge i_clk) begin
        if (en) begin
            p5_rad  <= (2*RB)'({1'b0, p4_sx} + {1'b0, p4_sy});
            p5_side <= {p4_gz, p4_satc, p4_rclip, p4_ox, p4_oy};
        end
    end

    // Root chain, one root bit per cell
    logic [RB:0]       sv;
    logic [RB:0]       srem  [RB+1];
    logic [RB-1:0]     sroot [RB+1];
    logic [2*RB-1:0]   sword [RB+1];
    logic [QS-1:0]     sside [RB+1];

    assign sv[0]    = r_qv[POST-1];
    assign srem[0]  = '0;
    assign sroot[0] = '0;
    assign sword[0] = p5_rad;
    assign sside[0] = p5_side;

    for (genvar k = 0; k < RB; k++) begin : g_sqrt
        ctp_sqrt_cell #(.ROOT_BITS(RB), .SIDE_BITS(QS)) u_cell (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en),
            .i_valid(sv[k]), .i_rem(srem[k]), .i_root(sroot[k]),
            .i_word(sword[k]), .i_side(sside[k]),
            .o_valid(sv[k+1]), .o_rem(srem[k+1]), .o_root(sroot[k+1]),
            .o_word(sword[k+1]), .o_side(sside[k+1])
        );
    end

    assign sq_v = sv[RB];

    // Result assembly
    logic                       f_gz, f_satc, f_rclip0, f_rclip;
    logic signed [OUT_BITS-1:0] f_ox, f_oy;
    logic [OUT_BITS-1:0]        f_rad;
    t_result                    res;

    assign {f_gz, f_satc, f_rclip0, f_ox, f_oy} = sside[RB];

    always_comb begin
        f_rclip = f_rclip0 || sroot[RB][RB-1];
        f_rad   = f_rclip ? OUT_MASK : sroot[RB][OUT_BITS-1:0];
        res     = '0;
        if (!f_gz) begin
            res.fit_valid  = 1'b1;
            res.center_x   = f_ox;
            res.center_y   = f_oy;
            res.radius_out = f_rad;
            res.radius_ok  = !f_rclip && (f_rad <= r_radius_limit);
            res.saturated  = f_satc || f_rclip;
        end
    end

    // Output register with one-entry skid buffer
    t_result r_out, r_skid;
    logic    out_free;
    assign out_free = !r_out_v || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (out_free) begin
            if (r_skid_v) begin
                r_out_v  <= 1'b1;
                r_skid_v <= 1'b0;
            end else begin
                r_out_v  <= sq_v;
            end
        end else if (sq_v && en) begin
            r_skid_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            r_out <= r_skid_v ? r_skid : res;
        end else if (sq_v && en) begin
            r_skid <= res;
        end
    end

    assign o_out_valid  = r_out_v;
    assign o_fit_valid  = r_out.fit_valid;
    assign o_center_x   = r_out.center_x;
    assign o_center_y   = r_out.center_y;
    assign o_radius_out = r_out.radius_out;
    assign o_radius_ok  = r_out.radius_ok;
    assign o_saturated  = r_out.saturated;

    // Checks
    `CTP_ASSERT(a_div_lockstep, xdiv_v == ydiv_v, "divider chains out of step")
    `CTP_ASSERT_ALWAYS(a_cfg_always_ready, o_cfg_ready, "config channel not ready")
    `CTP_ASSERT(a_skid_behind_out, r_skid_v |-> r_out_v, "skid entry without output")
    `CTP_ASSERT(a_invalid_zero, (o_out_valid && !o_fit_valid) |-> (o_radius_out == '0 && !o_radius_ok && !o_saturated), "collinear result not cleared")
    `CTP_ASSERT(a_ok_in_limit, (o_out_valid && o_radius_ok) |-> (o_fit_valid && o_radius_out <= r_radius_limit), "radius_ok beyond limit")

endmodule

// ----- rtl/ctp_div_cell.sv -----
// One restoring-division cell: produces one quotient bit per stage.
// Standalone; chained by the top level.
`timescale 1ns / 1ps

module ctp_div_cell #(
    parameter int DEN_BITS  = 26,
    parameter int QUOT_BITS = 43,
    parameter int SIDE_BITS = 1
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  logic [DEN_BITS-1:0]  i_rem,
    input  logic [QUOT_BITS-1:0] i_word,
    input  logic [DEN_BITS-1:0]  i_den,
    input  logic [SIDE_BITS-1:0] i_side,
    output logic                 o_valid,
    output logic [DEN_BITS-1:0]  o_rem,
    output logic [QUOT_BITS-1:0] o_word,
    output logic [DEN_BITS-1:0]  o_den,
    output logic [SIDE_BITS-1:0] o_side
);

    logic                 r_valid;
    logic [DEN_BITS-1:0]  r_rem, n_rem;
    logic [QUOT_BITS-1:0] r_word, n_word;
    logic [DEN_BITS-1:0]  r_den;
    logic [SIDE_BITS-1:0] r_side;

    logic [DEN_BITS:0]    cur;
    logic [DEN_BITS+1:0]  diff;
    logic                 ge;

    // Shift in the next dividend bit and try a subtract.
    always_comb begin
        cur    = {i_rem, i_word[QUOT_BITS-1]};
        diff   = {1'b0, cur} - {2'b00, i_den};
        ge     = !diff[DEN_BITS+1];
        n_rem  = ge ? diff[DEN_BITS-1:0] : cur[DEN_BITS-1:0];
        n_word = {i_word[QUOT_BITS-2:0], ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem  <= n_rem;
            r_word <= n_word;
            r_den  <= i_den;
            r_side <= i_side;
        end
    end

    assign o_valid = r_valid;
    assign o_rem   = r_rem;
    assign o_word  = r_word;
    assign o_den   = r_den;
    assign o_side  = r_side;

endmodule

// ----- rtl/ctp_sqrt_cell.sv -----
// One digit-by-digit square root cell: produces one root bit per stage.
// Standalone; chained by the top level.
`timescale 1ns / 1ps

module ctp_sqrt_cell #(
    parameter int ROOT_BITS = 25,
    parameter int SIDE_BITS = 1
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_en,
    input  logic                   i_valid,
    input  logic [ROOT_BITS:0]     i_rem,
    input  logic [ROOT_BITS-1:0]   i_root,
    input  logic [2*ROOT_BITS-1:0] i_word,
    input  logic [SIDE_BITS-1:0]   i_side,
    output logic                   o_valid,
    output logic [ROOT_BITS:0]     o_rem,
    output logic [ROOT_BITS-1:0]   o_root,
    output logic [2*ROOT_BITS-1:0] o_word,
    output logic [SIDE_BITS-1:0]   o_side
);

    logic                   r_valid;
    logic [ROOT_BITS:0]     r_rem, n_rem;
    logic [ROOT_BITS-1:0]   r_root, n_root;
    logic [2*ROOT_BITS-1:0] r_word, n_word;
    logic [SIDE_BITS-1:0]   r_side;

    logic [ROOT_BITS+1:0]   cur;
    logic [ROOT_BITS+1:0]   trial;
    logic [ROOT_BITS+2:0]   diff;
    logic                   ge;

    // Bring down two radicand bits and test 4*root+1.
    always_comb begin
        cur    = {i_rem[ROOT_BITS-1:0], i_word[2*ROOT_BITS-1 -: 2]};
        trial  = {i_root, 2'b01};
        diff   = {1'b0, cur} - {1'b0, trial};
        ge     = !diff[ROOT_BITS+2];
        n_rem  = ge ? diff[ROOT_BITS:0] : cur[ROOT_BITS:0];
        n_root = {i_root[ROOT_BITS-2:0], ge};
        n_word = {i_word[2*ROOT_BITS-3:0], 2'b00};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem  <= n_rem;
            r_root <= n_root;
            r_word <= n_word;
            r_side <= i_side;
        end
    end

    assign o_valid = r_valid;
    assign o_rem   = r_rem;
    assign o_root  = r_root;
    assign o_word  = r_word;
    assign o_side  = r_side;

endmodule

// ----- sim/tb.sv -----
// Self-checking testbench for circle_through_three_points: directed and random point triples.
// A local predictor computes each expected circle; depends on ctp_pkg and the block's RTL.
`timescale 1ns / 1ps

module tb;
    import ctp_pkg::*;

    localparam int  PIPE_DRAIN  = 100;
    localparam longint CYCLE_LIMIT = 400000;

    logic                       i_clk;
    logic                       i_rst_n;
    logic                       i_in_valid;
    logic                       o_in_ready;
    logic [11:0]                i_ax, i_ay, i_bx, i_by_coord, i_qx, i_qy;
    logic                       o_out_valid;
    logic                       i_out_ready;
    logic                       o_fit_valid;
    logic signed [OUT_BITS-1:0] o_center_x;
    logic signed [OUT_BITS-1:0] o_center_y;
    logic [OUT_BITS-1:0]        o_radius_out;
    logic                       o_radius_ok;
    logic                       o_saturated;
    logic                       i_cfg_valid;
    logic                       o_cfg_ready;
    logic [OUT_BITS-1:0]        i_cfg_data;

    t_result        circle_q[$];
    logic [23:0]    radius_limit;
    int             error_count;
    bit             quiet_phase;
    int             stall_left;
    longint         cycle_count;

    circle_through_three_points u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_ax         (i_ax),
        .i_ay         (i_ay),
        .i_bx         (i_bx),
        .i_by_coord   (i_by_coord),
        .i_qx         (i_qx),
        .i_qy         (i_qy),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_fit_valid  (o_fit_valid),
        .o_center_x   (o_center_x),
        .o_center_y   (o_center_y),
        .o_radius_out (o_radius_out),
        .o_radius_ok  (o_radius_ok),
        .o_saturated  (o_saturated),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data)
    );

    // Clock, 8 ns period
    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    // Floor square root, bit by bit
    function automatic longint unsigned floor_sqrt(input longint unsigned v);
        longint unsigned root;
        longint unsigned bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (v >= root + bitv) begin
                v    = v - (root + bitv);
                root = (root >> 1) + bitv;
            end else begin
                root = root >> 1;
            end
            bitv = bitv >> 2;
        end
        return root;
    endfunction

    // num * 16 / den, truncated toward zero
    function automatic longint frac_quotient(input longint num, input longint den);
        bit neg;
        longint unsigned un, ud, q;
        neg = (num < 0) != (den < 0);
        un  = (num < 0) ? -num : num;
        ud  = (den < 0) ? -den : den;
        q   = (un << 4) / ud;
        return neg ? -longint'(q) : longint'(q);
    endfunction

    // Expected circle through three points
    function automatic t_result predict_circle(input logic [11:0] ax, ay, bx, by, qx, qy,
                                               input logic [23:0] rmax);
        longint x1, y1, x2, y2, x3, y3;
        longint a, b, c, d, e, f, g, cx, cy, ox, oy, dx, dy;
        longint unsigned adx, ady, rad;
        bit sat, rclip;
        t_result r;
        x1 = ax; y1 = ay; x2 = bx; y2 = by; x3 = qx; y3 = qy;
        r  = '0;
        a = x2 - x1; b = y2 - y1; c = x3 - x1; d = y3 - y1;
        e = a * (x1 + x2) + b * (y1 + y2);
        f = c * (x1 + x3) + d * (y1 + y3);
        g = 2 * (a * (y3 - y2) - b * (x3 - x2));
        if (g == 0) return r;
        cx  = frac_quotient(d * e - b * f, g);
        cy  = frac_quotient(a * f - c * e, g);
        sat = 1'b0;
        ox  = cx;
        oy  = cy;
        if (ox > 8388607) begin ox = 8388607; sat = 1'b1; end
        if (ox < -8388608) begin ox = -8388608; sat = 1'b1; end
        if (oy > 8388607) begin oy = 8388607; sat = 1'b1; end
        if (oy < -8388608) begin oy = -8388608; sat = 1'b1; end
        // radius taken from the unclipped center
        dx  = cx - x1 * 16;
        dy  = cy - y1 * 16;
        adx = (dx < 0) ? -dx : dx;
        ady = (dy < 0) ? -dy : dy;
        rclip = 1'b0;
        if (adx > 64'hFFFFFF || ady > 64'hFFFFFF) begin
            rclip = 1'b1;
            rad   = 64'hFFFFFF;
        end else begin
            rad = floor_sqrt(adx * adx + ady * ady);
            if (rad > 64'hFFFFFF) begin
                rclip = 1'b1;
                rad   = 64'hFFFFFF;
            end
        end
        r.fit_valid  = 1'b1;
        r.center_x   = ox[23:0];
        r.center_y   = oy[23:0];
        r.radius_out = rad[23:0];
        r.radius_ok  = !rclip && (rad <= rmax);
        r.saturated  = sat | rclip;
        return r;
    endfunction

    task automatic report_mismatch(input string field, input longint got, input longint exp);
        $display("mismatch %s: got %0d expected %0d at cycle %0d", field, got, exp, cycle_count);
        error_count++;
    endtask

    // Result checker
    always @(posedge i_clk) begin
        t_result exp;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (circle_q.size() == 0) begin
                report_mismatch("unexpected result", 1, 0);
            end else begin
                exp = circle_q.pop_front();
                if (o_fit_valid !== exp.fit_valid)
                    report_mismatch("fit_valid", o_fit_valid, exp.fit_valid);
                if (o_center_x !== exp.center_x)
                    report_mismatch("center_x", o_center_x, exp.center_x);
                if (o_center_y !== exp.center_y)
                    report_mismatch("center_y", o_center_y, exp.center_y);
                if (o_radius_out !== exp.radius_out)
                    report_mismatch("radius_out", o_radius_out, exp.radius_out);
                if (o_radius_ok !== exp.radius_ok)
                    report_mismatch("radius_ok", o_radius_ok, exp.radius_ok);
                if (o_saturated !== exp.saturated)
                    report_mismatch("saturated", o_saturated, exp.saturated);
            end
        end
    end

    // Receiver backpressure in bursts
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            stall_left  <= stall_left - 1;
            i_out_ready <= 1'b0;
        end else if (!quiet_phase && $urandom_range(7) == 0) begin
            stall_left  <= $urandom_range(16);
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("circle_through_three_points regression: fail");
            $finish;
        end
    end

    // Send one point triple; entered and left at a falling edge
    task automatic send_points(input logic [11:0] ax, ay, bx, by, qx, qy);
        if (!quiet_phase && $urandom_range(3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(negedge i_clk);
        end
        i_ax <= ax; i_ay <= ay; i_bx <= bx;
        i_by_coord <= by; i_qx <= qx; i_qy <= qy;
        i_in_valid <= 1'b1;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        circle_q = {circle_q, predict_circle(ax, ay, bx, by, qx, qy, radius_limit)};
        @(negedge i_clk);
    endtask

    // Stop sending and wait for the pipeline to empty
    task automatic drain_pipeline();
        i_in_valid <= 1'b0;
        while (circle_q.size() != 0) @(negedge i_clk);
        repeat (PIPE_DRAIN) @(negedge i_clk);
    endtask

    task automatic write_radius_limit(input logic [23:0] value);
        drain_pipeline();
        i_cfg_data  <= value;
        i_cfg_valid <= 1'b1;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        radius_limit = value;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Field extremes and a plain circle
    task automatic test_extremes();
        send_points(12'd0, 12'd0, 12'd4095, 12'd0, 12'd0, 12'd4095);
        send_points(12'd4095, 12'd4095, 12'd0, 12'd4095, 12'd4095, 12'd0);
        send_points(12'd0, 12'd4095, 12'd4095, 12'd4095, 12'd2048, 12'd0);
        send_points(12'd100, 12'd100, 12'd110, 12'd100, 12'd100, 12'd110);
        send_points(12'd2730, 12'd1365, 12'd1365, 12'd2730, 12'd4095, 12'd4095);
    endtask

    // Collinear and coincident points
    task automatic test_collinear();
        send_points(12'd5, 12'd5, 12'd5, 12'd5, 12'd5, 12'd5);
        send_points(12'd0, 12'd0, 12'd4095, 12'd4095, 12'd2000, 12'd2000);
        send_points(12'd7, 12'd9, 12'd7, 12'd9, 12'd300, 12'd40);
        send_points(12'd0, 12'd10, 12'd4095, 12'd10, 12'd77, 12'd10);
    endtask

    // Nearly collinear points: center and radius clip
    task automatic test_saturation();
        send_points(12'd0, 12'd0, 12'd4095, 12'd1, 12'd4094, 12'd1);
        send_points(12'd0, 12'd0, 12'd4095, 12'd4094, 12'd4094, 12'd4093);
        send_points(12'd4095, 12'd0, 12'd0, 12'd4095, 12'd1, 12'd4095);
        send_points(12'd0, 12'd2048, 12'd4095, 12'd2049, 12'd2048, 12'd2048);
    endtask

    // Radius against the limit at several settings
    task automatic test_radius_limit();
        write_radius_limit(24'd0);
        send_points(12'd100, 12'd100, 12'd101, 12'd100, 12'd100, 12'd101);
        send_points(12'd0, 12'd0, 12'd4095, 12'd0, 12'd0, 12'd4095);
        write_radius_limit(24'hFFFFFF);
        send_points(12'd0, 12'd0, 12'd4095, 12'd0, 12'd0, 12'd4095);
        send_points(12'd0, 12'd0, 12'd4095, 12'd1, 12'd4094, 12'd1);
        write_radius_limit(24'd160);
        send_points(12'd100, 12'd100, 12'd120, 12'd100, 12'd100, 12'd120);
        send_points(12'd100, 12'd100, 12'd110, 12'd100, 12'd100, 12'd110);
    endtask

    // Random triples of several shapes
    task automatic test_random(input int count);
        logic [11:0] ax, ay, bx, by, qx, qy;
        int kind, t, cx0, cy0, span;
        for (int n = 0; n < count; n++) begin
            kind = $urandom_range(9);
            ax = 12'($urandom); ay = 12'($urandom); bx = 12'($urandom);
            by = 12'($urandom); qx = 12'($urandom); qy = 12'($urandom);
            if (kind < 4) begin
                // small local circle, often within the limit
                span = $urandom_range(1, 200);
                cx0 = $urandom_range(4095 - span); cy0 = $urandom_range(4095 - span);
                ax = 12'(cx0 + $urandom_range(span)); ay = 12'(cy0 + $urandom_range(span));
                bx = 12'(cx0 + $urandom_range(span)); by = 12'(cy0 + $urandom_range(span));
                qx = 12'(cx0 + $urandom_range(span)); qy = 12'(cy0 + $urandom_range(span));
            end else if (kind == 4) begin
                // exactly collinear
                t = $urandom_range(3);
                ax = 12'($urandom_range(1000)); ay = 12'($urandom_range(1000));
                bx = 12'(ax + $urandom_range(1000)); by = 12'(ay + $urandom_range(1000));
                qx = 12'(ax + (bx - ax) * t); qy = 12'(ay + (by - ay) * t);
            end else if (kind == 5) begin
                // nearly collinear
                ax = 12'($urandom_range(1000)); ay = 12'($urandom_range(1000));
                bx = 12'(ax + $urandom_range(1500)); by = 12'(ay + $urandom_range(1500));
                qx = 12'(2 * bx - ax + $urandom_range(1)); qy = 12'(2 * by - ay);
            end
            send_points(ax, ay, bx, by, qx, qy);
        end
    endtask

    initial begin
        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_out_ready  = 1'b0;
        i_cfg_valid  = 1'b0;
        i_cfg_data   = '0;
        i_ax = '0; i_ay = '0; i_bx = '0; i_by_coord = '0; i_qx = '0; i_qy = '0;
        radius_limit = 24'd2867;
        error_count  = 0;
        quiet_phase  = 1'b0;
        stall_left   = 0;
        cycle_count  = 0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        test_extremes();
        test_collinear();
        test_saturation();
        test_radius_limit();
        write_radius_limit(24'd2867);
        test_random(250);
        write_radius_limit(24'($urandom));
        test_random(200);
        write_radius_limit(24'($urandom_range(4000)));
        test_random(150);
        quiet_phase = 1'b1;
        test_random(100);

        drain_pipeline();
        if (error_count == 0) begin
            $display("circle_through_three_points regression: pass");
        end else begin
            $display("circle_through_three_points regression: fail");
        end
        $finish;
    end

endmodule
